@@ hw/rtl/rds_pkg.sv @@
`timescale 1ns / 1ps

package rds_pkg;

    localparam int DROP_STEPS = 3;
    localparam logic [7:0] HOLD_WRAP = 8'd250;

    // sequencer state codes
    localparam logic [2:0] ST_OFF   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXT   = 3'd2;
    localparam logic [2:0] ST_RET   = 3'd3;
    localparam logic [2:0] ST_ROLL  = 3'd4;
    localparam logic [2:0] ST_FAULT = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_DROP_FIRST  = 3'd0;
    localparam logic [2:0] CFG_DROP_SECOND = 3'd1;
    localparam logic [2:0] CFG_DROP_THIRD  = 3'd2;
    localparam logic [2:0] CFG_RAISED      = 3'd3;
    localparam logic [2:0] CFG_EXT_TMO     = 3'd4;
    localparam logic [2:0] CFG_RET_TMO     = 3'd5;
    localparam logic [2:0] CFG_FAN_TIME    = 3'd6;
    localparam logic [2:0] CFG_PRESS_MIN   = 3'd7;

    typedef struct packed {
        logic [15:0] drop_dist_first;
        logic [15:0] drop_dist_second;
        logic [15:0] drop_dist_third;
        logic [15:0] raised_height_mm;
        logic [31:0] extend_limit_ms;
        logic [31:0] retract_limit_ms;
        logic [31:0] fan_time_ms;
        logic [7:0]  press_min_ticks;
    } rds_cfg_t;

    typedef struct packed {
        logic        button_level;
        logic        monitor_trip;
        logic        sensor_healthy;
        logic [15:0] distance_mm;
        logic [31:0] now_ms;
    } rds_tick_t;

    typedef struct packed {
        logic motor;
        logic raised;
        logic fan;
    } rds_act_t;

    typedef struct packed {
        logic [2:0] state_code;
        rds_act_t   act;
        logic       press_seen;
    } rds_result_t;

endpackage

@@ hw/rtl/rds_seq.sv @@
`timescale 1ns / 1ps

module rds_seq
    import rds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  rds_tick_t   tick,
    input  rds_cfg_t    cfg,
    output rds_result_t result
);

    logic [2:0]  state_reg, state_next;
    logic [2:0]  prev_reg;
    logic [7:0]  held_reg, held_next;
    logic [1:0]  drop_reg, drop_next;
    logic [31:0] ext_start_reg, ext_start_next;
    logic [31:0] ret_start_reg, ret_start_next;
    logic [31:0] fan_start_reg, fan_start_next;
    rds_act_t    act_reg, act_next;

    logic        press;
    logic        sampled;
    logic [15:0] step_limit;
    logic        ext_done;

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        drop_next      = drop_reg;
        ext_start_next = ext_start_reg;
        ret_start_next = ret_start_reg;
        fan_start_next = fan_start_reg;
        act_next       = act_reg;
        press          = 1'b0;
        sampled        = 1'b0;
        step_limit     = cfg.drop_dist_third;
        ext_done       = 1'b0;

        // entry action on the first tick in a state
        if (prev_reg != state_reg)
        begin
            unique case (state_reg)
                ST_OFF:
                begin
                    act_next.motor  = 1'b0;
                    act_next.raised = 1'b0;
                end
                ST_IDLE:
                begin
                    act_next.motor  = 1'b0;
                    act_next.raised = 1'b1;
                    drop_next       = 2'd0;
                end
                ST_EXT:
                begin
                    act_next.motor  = 1'b1;
                    act_next.raised = 1'b0;
                    ext_start_next  = tick.now_ms;
                end
                ST_RET:
                begin
                    act_next.motor  = 1'b0;
                    act_next.raised = 1'b1;
                    ret_start_next  = tick.now_ms;
                end
                ST_ROLL:
                begin
                    act_next.motor = 1'b1;
                    act_next.fan   = 1'b1;
                    fan_start_next = tick.now_ms;
                end
                default:
                begin
                    act_next = '0;
                end
            endcase
        end

        // threshold index saturates at the last step
        priority if (drop_next == 2'd0)
            step_limit = cfg.drop_dist_first;
        else if (drop_next == 2'd1 && DROP_STEPS > 1)
            step_limit = cfg.drop_dist_second;
        else if (DROP_STEPS > 2)
            step_limit = cfg.drop_dist_third;
        else if (DROP_STEPS > 1)
            step_limit = cfg.drop_dist_second;
        else
            step_limit = cfg.drop_dist_first;

        ext_done = (tick.sensor_healthy && tick.distance_mm > step_limit) ||
                   ((tick.now_ms - ext_start_next) > cfg.extend_limit_ms);

        unique case (state_reg)
            ST_OFF, ST_IDLE:
            begin
                if (tick.monitor_trip)
                    state_next = ST_FAULT;
                else
                    sampled = 1'b1;
            end
            ST_EXT:
            begin
                if (tick.monitor_trip)
                    state_next = ST_FAULT;
                else if (ext_done)
                begin
                    if (drop_next != 2'd3)
                        drop_next = drop_next + 2'd1;
                    state_next = ST_RET;
                end
                else
                    sampled = 1'b1;
            end
            ST_RET:
            begin
                if (tick.monitor_trip)
                    state_next = ST_FAULT;
                else if (tick.distance_mm < cfg.raised_height_mm ||
                         (tick.now_ms - ret_start_next) > cfg.retract_limit_ms)
                    state_next = ST_ROLL;
            end
            ST_ROLL:
            begin
                if (tick.monitor_trip)
                    state_next = ST_FAULT;
                else if ((tick.now_ms - fan_start_next) > cfg.fan_time_ms)
                begin
                    act_next.fan = 1'b0;
                    state_next   = ({30'd0, drop_next} < 32'(DROP_STEPS)) ? ST_EXT
                                                                          : ST_IDLE;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase

        // button debounce, only where the sequencer polls it
        if (sampled)
        begin
            if (!tick.button_level && held_reg < HOLD_WRAP)
                held_next = held_reg + 8'd1;
            else if (tick.button_level && held_reg >= cfg.press_min_ticks)
            begin
                held_next = 8'd0;
                press     = 1'b1;
            end
            else
                held_next = 8'd0;

            if (press)
            begin
                unique case (state_reg)
                    ST_OFF:  state_next = ST_IDLE;
                    ST_IDLE: state_next = ST_EXT;
                    default: state_next = ST_OFF;
                endcase
            end
        end
    end

    assign result.state_code = state_next;
    assign result.act        = act_next;
    assign result.press_seen = press;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_OFF;
            prev_reg      <= ST_OFF;
            held_reg      <= '0;
            drop_reg      <= '0;
            ext_start_reg <= '0;
            ret_start_reg <= '0;
            fan_start_reg <= '0;
            act_reg       <= '0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            prev_reg      <= state_reg;
            held_reg      <= held_next;
            drop_reg      <= drop_next;
            ext_start_reg <= ext_start_next;
            ret_start_reg <= ret_start_next;
            fan_start_reg <= fan_start_next;
            act_reg       <= act_next;
        end
    end

endmodule

@@ hw/rtl/roller_drop_sequencer.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// in        sink       in_valid / in_ready     button_level monitor_trip sensor_healthy
//                                              distance_mm now_ms
// out       source     out_valid / out_ready   state_code motor_enable roller_raised
//                                              fan_on press_seen
// cfg       sink       cfg_valid / cfg_ready   cfg_index cfg_data
//
// one request per cycle sustained while out_ready stays high; each result is presented
// once its request is taken and advances: the request sits in the input register while
// the sequencer update is computed, and the result register loads as it advances.
// reset returns the sequencer to off and the configuration to defaults, and clears
// both valid flags. a stalled result holds the input register, and a new request is still
// taken whenever the result register drains in the same cycle. cfg_ready is always high.

module roller_drop_sequencer
    import rds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        button_level,
    input  logic        monitor_trip,
    input  logic        sensor_healthy,
    input  logic [15:0] distance_mm,
    input  logic [31:0] now_ms,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  state_code,
    output logic        motor_enable,
    output logic        roller_raised,
    output logic        fan_on,
    output logic        press_seen,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    rds_cfg_t    cfg_reg;
    rds_tick_t   tick_reg;
    logic        tick_vld_reg;
    rds_result_t res_reg;
    logic        res_vld_reg;
    rds_result_t res_next;
    logic        advance;

    assign cfg_ready = 1'b1;
    assign advance   = tick_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready  = !tick_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drop_dist_first    <= 16'd60;
            cfg_reg.drop_dist_second   <= 16'd80;
            cfg_reg.drop_dist_third    <= 16'd90;
            cfg_reg.raised_height_mm   <= 16'd40;
            cfg_reg.extend_limit_ms    <= 32'd8000;
            cfg_reg.retract_limit_ms   <= 32'd5000;
            cfg_reg.fan_time_ms        <= 32'd5000;
            cfg_reg.press_min_ticks    <= 8'd3;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DROP_FIRST:  cfg_reg.drop_dist_first    <= cfg_data[15:0];
                CFG_DROP_SECOND: cfg_reg.drop_dist_second   <= cfg_data[15:0];
                CFG_DROP_THIRD:  cfg_reg.drop_dist_third    <= cfg_data[15:0];
                CFG_RAISED:      cfg_reg.raised_height_mm   <= cfg_data[15:0];
                CFG_EXT_TMO:     cfg_reg.extend_limit_ms    <= cfg_data;
                CFG_RET_TMO:     cfg_reg.retract_limit_ms   <= cfg_data;
                CFG_FAN_TIME:    cfg_reg.fan_time_ms        <= cfg_data;
                CFG_PRESS_MIN:   cfg_reg.press_min_ticks    <= cfg_data[7:0];
                default:         cfg_reg.press_min_ticks    <= cfg_reg.press_min_ticks;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                tick_vld_reg <= in_valid;
            if (advance)
                res_vld_reg <= 1'b1;
            else if (out_ready)
                res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tick_reg.button_level   <= button_level;
            tick_reg.monitor_trip   <= monitor_trip;
            tick_reg.sensor_healthy <= sensor_healthy;
            tick_reg.distance_mm    <= distance_mm;
            tick_reg.now_ms         <= now_ms;
        end
        if (advance)
            res_reg <= res_next;
    end

    rds_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tick    (tick_reg),
        .cfg     (cfg_reg),
        .result  (res_next)
    );

    assign out_valid     = res_vld_reg;
    assign state_code    = res_reg.state_code;
    assign motor_enable  = res_reg.act.motor;
    assign roller_raised = res_reg.act.raised;
    assign fan_on        = res_reg.act.fan;
    assign press_seen    = res_reg.press_seen;

endmodule
